// ----- rtl/utl_pkg.sv -----
package utl_pkg;

  typedef logic signed [19:0] code_point_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       triple;
    logic       string_end;
  } utl_entry_t;

  localparam logic [7:0] AsciiLimit    = 8'h80;
  localparam logic [7:0] ThreeByteLead = 8'hE0;
  localparam logic [7:0] TwoByteBase   = 8'hC0;
  localparam logic [7:0] ContBase      = 8'h80;

  localparam code_point_t CpLatinLimit = 20'sh00100;
  localparam code_point_t CpLdquo      = 20'sh0201C;
  localparam code_point_t CpRdquo      = 20'sh0201D;
  localparam code_point_t CpLsquo      = 20'sh02018;
  localparam code_point_t CpRsquo      = 20'sh02019;
  localparam code_point_t CpEndash     = 20'sh02013;
  localparam code_point_t CpEmdash     = 20'sh02014;
  localparam code_point_t CpEuro       = 20'sh020AC;
  localparam code_point_t CpArrow      = 20'sh027A2;
  localparam code_point_t CpLozenge    = 20'sh025CA;
  localparam code_point_t CpPrivA      = 20'sh0F076;
  localparam code_point_t CpPrivB      = 20'sh0F0A7;
  localparam code_point_t CpPrivC      = 20'sh0F0B7;
  localparam code_point_t CpBullet     = 20'sh02022;
  localparam code_point_t CpEllipsis   = 20'sh02026;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChApostr    = 8'h27;
  localparam logic [7:0] ChDash      = 8'h2D;
  localparam logic [7:0] ChCurrency  = 8'hA4;
  localparam logic [7:0] ChMiddleDot = 8'hB7;
  localparam logic [7:0] ChPeriod    = 8'h2E;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChNul       = 8'h00;

  localparam logic [1:0] PendIdle  = 2'd0;
  localparam logic [1:0] PendOne   = 2'd1;
  localparam logic [1:0] PendTwo   = 2'd2;

  localparam logic [1:0] TripleLast = 2'd2;

endpackage

// ----- rtl/utl_front.sv -----
module utl_front
  import utl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  output logic       push_o,
  output utl_entry_t push_entry_o,
  input  logic       queue_ready_i
);

  logic [1:0] pending_q, pending_d;
  logic [7:0] lead_q, lead_d;
  logic [7:0] second_q, second_d;
  logic       accept;
  code_point_t cp;

  function automatic utl_entry_t map_point(code_point_t c);
    utl_entry_t e;
    e.out_byte   = ChSpace;
    e.triple     = 1'b0;
    e.string_end = 1'b0;
    if (c < CpLatinLimit) begin
      e.out_byte = c[7:0];
    end else if (c == CpLdquo || c == CpRdquo) begin
      e.out_byte = ChQuote;
    end else if (c == CpLsquo || c == CpRsquo) begin
      e.out_byte = ChApostr;
    end else if (c == CpEndash || c == CpEmdash) begin
      e.out_byte = ChDash;
    end else if (c == CpEuro) begin
      e.out_byte = ChCurrency;
    end else if (c == CpArrow || c == CpLozenge || c == CpPrivA || c == CpPrivB ||
                 c == CpPrivC || c == CpBullet) begin
      e.out_byte = ChMiddleDot;
    end else if (c == CpEllipsis) begin
      e.out_byte = ChPeriod;
      e.triple   = 1'b1;
    end
    return e;
  endfunction

  assign in_ready_o = queue_ready_i;
  assign accept     = in_valid_i && queue_ready_i;

  always_comb begin
    if (lead_q < ThreeByteLead) begin
      cp = ($signed({12'd0, lead_q}) - $signed({12'd0, TwoByteBase})) * 20'sd64
         + ($signed({12'd0, in_byte_i}) - $signed({12'd0, ContBase}));
    end else begin
      cp = ($signed({12'd0, lead_q}) - $signed({12'd0, ThreeByteLead})) * 20'sd4096
         + ($signed({12'd0, second_q}) - $signed({12'd0, ContBase})) * 20'sd64
         + ($signed({12'd0, in_byte_i}) - $signed({12'd0, ContBase}));
    end
  end

  always_comb begin
    pending_d    = pending_q;
    lead_d       = lead_q;
    second_d     = second_q;
    push_o       = 1'b0;
    push_entry_o = '{out_byte: in_byte_i, triple: 1'b0, string_end: 1'b0};
    if (accept) begin
      if (in_byte_i == ChNul) begin
        pending_d    = PendIdle;
        push_o       = 1'b1;
        push_entry_o = '{out_byte: ChNul, triple: 1'b0, string_end: 1'b1};
      end else if (pending_q == PendIdle) begin
        if (in_byte_i < AsciiLimit) begin
          push_o = 1'b1;
        end else begin
          lead_d    = in_byte_i;
          pending_d = (in_byte_i < ThreeByteLead) ? PendOne : PendTwo;
        end
      end else if (pending_q == PendTwo) begin
        second_d  = in_byte_i;
        pending_d = PendOne;
      end else begin
        pending_d    = PendIdle;
        push_o       = 1'b1;
        push_entry_o = map_point(cp);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= PendIdle;
      lead_q    <= '0;
      second_q  <= '0;
    end else begin
      pending_q <= pending_d;
      lead_q    <= lead_d;
      second_q  <= second_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && push_entry_o.string_end |-> push_entry_o.out_byte == ChNul &&
                                          !push_entry_o.triple)
    else $error("Terminator entry is malformed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_byte_i == ChNul |=> pending_q == PendIdle)
    else $error("Zero byte did not return the decoder to idle.");

endmodule

// ----- rtl/utl_fifo.sv -----
module utl_fifo
  import utl_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  utl_entry_t push_entry_i,
  output logic       ready_o,
  input  logic       pop_i,
  output logic       valid_o,
  output utl_entry_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  utl_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign ready_o = count_q != CntW'(Depth);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Queue count exceeds its depth.");

endmodule

// ----- rtl/utl_back.sv -----
module utl_back
  import utl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  utl_entry_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire;

  assign out_valid_o  = valid_i;
  assign out_byte_o   = head_i.out_byte;
  assign string_end_o = head_i.string_end;
  assign run_last_o   = !head_i.triple || idx_q == TripleLast;
  assign fire         = valid_i && out_ready_i;
  assign pop_o        = fire && run_last_o;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = run_last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= TripleLast)
    else $error("Repeat index ran past the last period.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> valid_i && head_i.triple)
    else $error("Repeat index is busy without a triple entry at the head.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_last_o && out_byte_o == ChNul)
    else $error("Terminator item lacks its last flag or zero byte.");

endmodule

// ----- rtl/utf8_to_latin1_transliterator.sv -----
// UTF-8 to ISO-8859-1 transliterating decoder.
// Input: one UTF-8 byte per item on s_axis_tdata_i[7:0]. Output: one ISO-8859-1
// byte per item on m_axis_tdata_o[7:0]; tlast marks the last item caused by one
// input byte and tuser marks the terminating zero of a string.
// A front stage tracks the sequence and maps each completed code point into a
// queue entry; a back stage drains the queue and repeats the period three times
// for the ellipsis. The queue holds FifoDepth entries.
// A byte that completes a character is written into the queue; with the queue
// empty its item is visible at the output in the cycle after it is accepted.
// Lead and middle bytes give no item. Throughput is one input byte per cycle
// while s_axis_tready_o is high; the repeat counter holds the ellipsis at the
// output through its third period. With the default depth the queue holds one
// more entry behind it; once full, s_axis_tready_o is low until it leaves.
// Reset clears the sequence state, the repeat counter and empties the queue.
// When the receiver stalls, the head item holds on the output, the queue fills,
// and s_axis_tready_o drops once the queue is full.
module utf8_to_latin1_transliterator
  import utl_pkg::*;
#(
  parameter int FifoDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,
  output logic       m_axis_tuser_o    // [0] string_end
);

  logic       push;
  utl_entry_t push_entry;
  logic       queue_ready;
  logic       queue_valid;
  logic       pop;
  utl_entry_t head;

  utl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_byte_i     (s_axis_tdata_i),
    .in_ready_o    (s_axis_tready_o),
    .push_o        (push),
    .push_entry_o  (push_entry),
    .queue_ready_i (queue_ready)
  );

  utl_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (queue_ready),
    .pop_i        (pop),
    .valid_o      (queue_valid),
    .head_o       (head)
  );

  utl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (queue_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .run_last_o   (m_axis_tlast_o),
    .string_end_o (m_axis_tuser_o)
  );

endmodule
